>>> rtl/core/rbf_pkg.sv
// Shared types, constants and helpers for the raster blit with reflection fade.
package rbf_pkg;

	localparam int FMT_W      = 2;
	localparam int UNITS_W    = 13;
	localparam int ROWS_W     = 13;
	localparam int REFL_W     = 12;
	localparam int STRIDE_W   = 15;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;
	localparam int OFF_W      = 27;
	localparam int PIX_W      = 32;
	localparam int FADE_QW    = 7;   // fade factor is at most 64

	localparam logic [PIX_W-1:0] PIX_BIT_SET   = 32'h0000_0000;
	localparam logic [PIX_W-1:0] PIX_BIT_CLEAR = 32'hFFFF_FFFF;

	typedef enum logic [FMT_W-1:0] {
		FMT_BILEVEL = 2'd0,
		FMT_COPY16  = 2'd1,
		FMT_COPY32  = 2'd2,
		FMT_SWAP32  = 2'd3
	} fmt_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PIXEL_FORMAT    = 3'd0,
		CFG_ROW_UNITS       = 3'd1,
		CFG_IMAGE_ROWS      = 3'd2,
		CFG_REFLECTION_ROWS = 3'd3,
		CFG_DEST_STRIDE     = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		fmt_t                pixel_format;
		logic [UNITS_W-1:0]  row_units;
		logic [ROWS_W-1:0]   image_rows;
		logic [REFL_W-1:0]   reflection_rows;
		logic [STRIDE_W-1:0] dest_stride;
	} cfg_regs_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_ROW,
		ST_SUM_ROW,
		ST_DIV,
		ST_EMIT_DIR,
		ST_EMIT_MIR
	} seq_state_t;

	// zero acts as one, oversize acts as the limit
	function automatic logic [31:0] clamp_dim(logic [ROWS_W-1:0] v, logic [31:0] hi);
		logic [31:0] r;
		if (v == '0) begin
			r = 32'd1;
		end else if (32'(v) > hi) begin
			r = hi;
		end else begin
			r = 32'(v);
		end
		return r;
	endfunction

	// each byte scaled by f/256, truncated
	function automatic logic [PIX_W-1:0] fade_pixel(logic [PIX_W-1:0] p,
			logic [FADE_QW-1:0] f);
		logic [PIX_W-1:0]     r;
		logic [FADE_QW+7:0]   prod;
		r = '0;
		for (int k = 0; k < 4; k++) begin
			prod = (FADE_QW+8)'(p[8*k +: 8]) * (FADE_QW+8)'(f);
			r[8*k +: 8] = 8'(prod >> 8);
		end
		return r;
	endfunction

endpackage

>>> rtl/core/raster_blit_with_reflection_fade.sv
// Top level: configuration registers, row/column tracking and the write sequencer.
//
// Each source request becomes framebuffer writes at row*dest_stride + column*P*bpp:
// eight 32-bit pixels from the low byte in bilevel format (P = 8), one pixel otherwise
// (P = 1), followed by the same number of faded writes to the mirrored row when
// the row lies in the bottom reflection band. Writes leave one per cycle through the
// single write port and an output register while the sink keeps up. A request passes
// through the shared row-base multiplier, for the direct row and then for the mirrored
// one, and a reflected row also waits on the bit-serial fade divider (seven quotient
// steps).
// src_ready is low while a request is being worked; configuration writes are
// taken at any time but must only be issued while the block is idle.
module raster_blit_with_reflection_fade
	import rbf_pkg::*;
#(
	parameter int MAX_ROWS      = 4096,
	parameter int MAX_ROW_UNITS = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  src_valid,
	output logic                  src_ready,
	input  logic [PIX_W-1:0]      source_unit,
	output logic                  wr_valid,
	input  logic                  wr_ready,
	output logic [OFF_W-1:0]      dest_offset,
	output logic [PIX_W-1:0]      pixel_data,
	output logic                  is_reflection,
	output logic                  last
);

	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW = (MAX_ROW_UNITS > 1) ? $clog2(MAX_ROW_UNITS) : 1;
	localparam int HW = $clog2(MAX_ROWS+1);
	localparam int UW = $clog2(MAX_ROW_UNITS+1);

	cfg_regs_t     cfg_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic [HW-1:0] h;
	logic [UW-1:0] w;
	logic          accept;
	logic          row_end;
	logic          frame_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_format    <= FMT_BILEVEL;
			cfg_q.row_units       <= UNITS_W'(1);
			cfg_q.image_rows      <= ROWS_W'(1);
			cfg_q.reflection_rows <= '0;
			cfg_q.dest_stride     <= STRIDE_W'(1);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_PIXEL_FORMAT:    cfg_q.pixel_format    <= fmt_t'(cfg_data[FMT_W-1:0]);
				CFG_ROW_UNITS:       cfg_q.row_units       <= cfg_data[UNITS_W-1:0];
				CFG_IMAGE_ROWS:      cfg_q.image_rows      <= cfg_data[ROWS_W-1:0];
				CFG_REFLECTION_ROWS: cfg_q.reflection_rows <= cfg_data[REFL_W-1:0];
				CFG_DEST_STRIDE:     cfg_q.dest_stride     <= cfg_data[STRIDE_W-1:0];
				default: ;
			endcase
		end
	end

	assign w = UW'(clamp_dim(cfg_q.row_units, 32'(MAX_ROW_UNITS)));
	assign h = HW'(clamp_dim(cfg_q.image_rows, 32'(MAX_ROWS)));

	// position advances at accept; a bound reached or passed wraps to zero
	assign accept    = src_valid && src_ready;
	assign row_end   = (32'(col_q) + 32'd1) >= 32'(w);
	assign frame_end = (32'(row_q) + 32'd1) >= 32'(h);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	rbf_seq #(
		.MAX_ROWS      (MAX_ROWS),
		.MAX_ROW_UNITS (MAX_ROW_UNITS)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.h             (h),
		.row           (row_q),
		.col           (col_q),
		.src_valid     (src_valid),
		.src_ready     (src_ready),
		.source_unit   (source_unit),
		.wr_valid      (wr_valid),
		.wr_ready      (wr_ready),
		.dest_offset   (dest_offset),
		.pixel_data    (pixel_data),
		.is_reflection (is_reflection),
		.last          (last)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !src_ready)
		else $error("sequencer ready right after taking a request");

	a_col_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(col_q) && $stable(row_q))
		else $error("position moved without a request");

	a_refl_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		wr_valid && is_reflection |-> cfg_q.reflection_rows != '0)
		else $error("mirrored write with reflection disabled");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(row_q) < 32'(MAX_ROWS))
		else $error("row count beyond maximum");

endmodule

>>> rtl/core/rbf_div.sv
// Iterative restoring divider for the fade factor floor(n*64/r), one bit per cycle.
module rbf_div
	import rbf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [REFL_W-1:0]  num,
	input  logic [REFL_W-1:0]  den,
	output logic               busy,
	output logic [FADE_QW-1:0] quot
);

	logic [REFL_W-1:0]           rem_q;
	logic                        nbit_q;
	logic [FADE_QW-1:0]          quot_q;
	logic [$clog2(FADE_QW+1)-1:0] cnt_q;
	logic                        busy_q;
	logic [REFL_W:0]             trial;
	logic                        fits;

	// dividend is num<<6; its bits above the quotient range seed the remainder
	assign trial = {rem_q, nbit_q};
	assign fits  = trial >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= ($clog2(FADE_QW+1))'(FADE_QW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == ($clog2(FADE_QW+1))'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {1'b0, num[REFL_W-1:1]};
			nbit_q <= num[0];
			quot_q <= '0;
		end else if (busy_q) begin
			nbit_q <= 1'b0;
			quot_q <= {quot_q[FADE_QW-2:0], fits};
			if (fits) begin
				rem_q <= REFL_W'(trial - {1'b0, den});
			end else begin
				rem_q <= trial[REFL_W-1:0];
			end
		end
	end

	assign busy = busy_q;
	assign quot = quot_q;

endmodule

>>> rtl/core/rbf_seq.sv
// Per-request sequencer: shared row multiplier, fade divider, write emission and output register.
module rbf_seq
	import rbf_pkg::*;
#(
	parameter int MAX_ROWS      = 4096,
	parameter int MAX_ROW_UNITS = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_regs_t           cfg,
	input  logic [$clog2(MAX_ROWS+1)-1:0] h,
	input  logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] row,
	input  logic [((MAX_ROW_UNITS > 1) ? $clog2(MAX_ROW_UNITS) : 1)-1:0] col,
	input  logic                src_valid,
	output logic                src_ready,
	input  logic [PIX_W-1:0]    source_unit,
	output logic                wr_valid,
	input  logic                wr_ready,
	output logic [OFF_W-1:0]    dest_offset,
	output logic [PIX_W-1:0]    pixel_data,
	output logic                is_reflection,
	output logic                last
);

	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW = (MAX_ROW_UNITS > 1) ? $clog2(MAX_ROW_UNITS) : 1;
	localparam int HW = $clog2(MAX_ROWS+1);

	seq_state_t state_q, state_d;

	logic [PIX_W-1:0]     src_q;
	logic [RW-1:0]        row_q;
	logic [CW-1:0]        col_q;
	logic [OFF_W-1:0]     prod_q;
	logic [OFF_W-1:0]     off_q;
	logic [OFF_W-1:0]     moff_q;
	logic                 refl_q;
	logic [2:0]           pix_q;

	logic                 wr_valid_q;
	logic [OFF_W-1:0]     wr_off_q;
	logic [PIX_W-1:0]     wr_data_q;
	logic                 wr_refl_q;
	logic                 wr_last_q;

	logic                 accept;
	logic                 load;
	logic                 div_start;
	logic                 div_busy;
	logic [FADE_QW-1:0]   fade_f;

	logic [REFL_W-1:0]    r;
	logic [HW-1:0]        lo;
	logic                 refl;
	logic [REFL_W-1:0]    n;
	logic [HW:0]          mrow;
	logic [HW:0]          mul_a;
	logic [HW+STRIDE_W:0] mul_p;
	logic [OFF_W-1:0]     base;
	logic [OFF_W-1:0]     bpp;
	logic                 last_pix;
	logic [2:0]           bit_idx;
	logic [PIX_W-1:0]     pix;

	// geometry of this row
	assign r    = (32'(cfg.reflection_rows) > 32'(h)) ? REFL_W'(h) : cfg.reflection_rows;
	assign lo   = h - HW'(r);
	assign refl = (r != '0) && (HW'(row_q) >= lo) && (HW'(row_q) < h);
	assign n    = REFL_W'(32'(row_q) - 32'(lo) + 32'd1);
	assign mrow = ({1'b0, h} << 1) - (HW+1)'(1) - (HW+1)'(row_q);

	// one multiplier serves both the direct and the mirrored row base
	assign mul_a = (state_q == ST_MUL_ROW) ? (HW+1)'(row_q) : mrow;
	assign mul_p = (HW+STRIDE_W+1)'(mul_a) * (HW+STRIDE_W+1)'(cfg.dest_stride);

	always_comb begin
		unique case (cfg.pixel_format)
			FMT_BILEVEL: begin
				base = OFF_W'(col_q) << 5;
				bpp  = OFF_W'(4);
			end
			FMT_COPY16: begin
				base = OFF_W'(col_q) << 1;
				bpp  = OFF_W'(2);
			end
			default: begin
				base = OFF_W'(col_q) << 2;
				bpp  = OFF_W'(4);
			end
		endcase
	end

	// bilevel expands MSB first
	assign bit_idx = ~pix_q;

	always_comb begin
		unique case (cfg.pixel_format)
			FMT_BILEVEL: pix = src_q[bit_idx] ? PIX_BIT_SET : PIX_BIT_CLEAR;
			FMT_COPY16:  pix = {16'h0000, src_q[15:0]};
			FMT_COPY32:  pix = src_q;
			default:     pix = {src_q[7:0], src_q[15:8], src_q[23:16], src_q[31:24]};
		endcase
	end

	assign last_pix = (cfg.pixel_format != FMT_BILEVEL) || (pix_q == 3'd7);

	rbf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (n),
		.den    (r),
		.busy   (div_busy),
		.quot   (fade_f)
	);

	// handshake and strobes
	always_comb begin
		src_ready = (state_q == ST_IDLE);
		accept    = src_valid && src_ready;
		load      = ((state_q == ST_EMIT_DIR) || (state_q == ST_EMIT_MIR)) &&
		            (!wr_valid_q || wr_ready);
		div_start = (state_q == ST_SUM_ROW) && refl;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (accept) state_d = ST_MUL_ROW;
			ST_MUL_ROW:  state_d = ST_SUM_ROW;
			ST_SUM_ROW:  state_d = refl ? ST_DIV : ST_EMIT_DIR;
			ST_DIV:      if (!div_busy) state_d = ST_EMIT_DIR;
			ST_EMIT_DIR: begin
				if (load && last_pix) state_d = refl_q ? ST_EMIT_MIR : ST_IDLE;
			end
			ST_EMIT_MIR: if (load && last_pix) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			wr_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				wr_valid_q <= 1'b1;
			end else if (wr_ready) begin
				wr_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					src_q <= source_unit;
					row_q <= row;
					col_q <= col;
					pix_q <= '0;
				end
			end
			ST_MUL_ROW: prod_q <= OFF_W'(mul_p);
			ST_SUM_ROW: begin
				off_q  <= prod_q + base;
				refl_q <= refl;
				prod_q <= OFF_W'(mul_p);
			end
			ST_DIV: moff_q <= prod_q + base;
			ST_EMIT_DIR: begin
				if (load) begin
					wr_off_q  <= off_q;
					wr_data_q <= pix;
					wr_refl_q <= 1'b0;
					wr_last_q <= last_pix && !refl_q;
					off_q     <= off_q + bpp;
					pix_q     <= last_pix ? 3'd0 : pix_q + 3'd1;
				end
			end
			ST_EMIT_MIR: begin
				if (load) begin
					wr_off_q  <= moff_q;
					wr_data_q <= fade_pixel(pix, fade_f);
					wr_refl_q <= 1'b1;
					wr_last_q <= last_pix;
					moff_q    <= moff_q + bpp;
					pix_q     <= last_pix ? 3'd0 : pix_q + 3'd1;
				end
			end
			default: ;
		endcase
	end

	assign wr_valid      = wr_valid_q;
	assign dest_offset   = wr_off_q;
	assign pixel_data    = wr_data_q;
	assign is_reflection = wr_refl_q;
	assign last          = wr_last_q;

endmodule

>>> sim/tb.sv
// Testbench for the raster blit with reflection fade: predicted framebuffer writes vs. the block.

class blit_scoreboard;
	typedef struct packed {
		logic [26:0] off;
		logic [31:0] data;
		logic        refl;
		logic        last;
	} fb_write_t;

	rbf_pkg::fmt_t fmt;
	logic [12:0]   units;
	logic [12:0]   rows;
	logic [11:0]   refl_rows;
	logic [14:0]   stride;
	logic [11:0]   row_cnt;
	logic [11:0]   col_cnt;

	fb_write_t expected_writes[$];
	int        mismatches;
	int        units_seen;
	int        writes_seen;
	int        mirrored_seen;

	function new();
		fmt           = rbf_pkg::FMT_BILEVEL;
		units         = 13'd1;
		rows          = 13'd1;
		refl_rows     = 12'd0;
		stride        = 15'd1;
		row_cnt       = '0;
		col_cnt       = '0;
		mismatches    = 0;
		units_seen    = 0;
		writes_seen   = 0;
		mirrored_seen = 0;
	endfunction

	function void set_reg(rbf_pkg::cfg_idx_t idx, logic [14:0] v);
		case (idx)
			rbf_pkg::CFG_PIXEL_FORMAT:    fmt = rbf_pkg::fmt_t'(v[1:0]);
			rbf_pkg::CFG_ROW_UNITS:       units = v[12:0];
			rbf_pkg::CFG_IMAGE_ROWS:      rows = v[12:0];
			rbf_pkg::CFG_REFLECTION_ROWS: refl_rows = v[11:0];
			rbf_pkg::CFG_DEST_STRIDE:     stride = v;
			default: ;
		endcase
	endfunction

	function int unsigned fit_dim(logic [12:0] v, int unsigned hi);
		if (v == '0)
			return 1;
		return (32'(v) > hi) ? hi : 32'(v);
	endfunction

	function logic [31:0] fade_word(logic [31:0] p, int unsigned f);
		logic [31:0] r;
		int unsigned b;
		r = '0;
		for (int k = 0; k < 4; k++) begin
			b = 32'(p[8*k +: 8]);
			r[8*k +: 8] = 8'((b * f) >> 8);
		end
		return r;
	endfunction

	// expected writes for one accepted source request, then advance the position
	function void note_unit(logic [31:0] src);
		int unsigned w, h, r, row, col, npix, bpp, base, n, f, mrow, nxt;
		logic [31:0] pix[8];
		fb_write_t   wlist[16];
		int          k;
		bit          mirrored;
		w   = fit_dim(units, 4096);
		h   = fit_dim(rows, 4096);
		r   = (32'(refl_rows) > h) ? h : 32'(refl_rows);
		row = 32'(row_cnt);
		col = 32'(col_cnt);
		k   = 0;
		case (fmt)
			rbf_pkg::FMT_BILEVEL: begin
				for (int i = 0; i < 8; i++)
					pix[i] = src[7-i] ? rbf_pkg::PIX_BIT_SET : rbf_pkg::PIX_BIT_CLEAR;
				npix = 8;
				bpp  = 4;
				base = col * 32;
			end
			rbf_pkg::FMT_COPY16: begin
				pix[0] = {16'h0000, src[15:0]};
				npix = 1;
				bpp  = 2;
				base = col * 2;
			end
			rbf_pkg::FMT_COPY32: begin
				pix[0] = src;
				npix = 1;
				bpp  = 4;
				base = col * 4;
			end
			default: begin
				pix[0] = {src[7:0], src[15:8], src[23:16], src[31:24]};
				npix = 1;
				bpp  = 4;
				base = col * 4;
			end
		endcase
		for (int i = 0; i < npix; i++) begin
			wlist[k] = '{off: 27'(row * 32'(stride) + base + i * bpp), data: pix[i],
				refl: 1'b0, last: 1'b0};
			k++;
		end
		// rows at or past the image height never get a mirrored copy
		mirrored = (r != 0) && (row >= h - r) && (row < h);
		if (mirrored) begin
			n    = row - (h - r) + 1;
			f    = (n * 64) / r;
			mrow = 2 * h - 1 - row;
			for (int i = 0; i < npix; i++) begin
				wlist[k] = '{off: 27'(mrow * 32'(stride) + base + i * bpp),
					data: fade_word(pix[i], f), refl: 1'b1, last: 1'b0};
				k++;
			end
		end
		wlist[k-1].last = 1'b1;
		for (int j = 0; j < k; j++)
			expected_writes.push_back(wlist[j]);
		nxt = col + 1;
		if (nxt >= w) begin
			col_cnt = '0;
			nxt = row + 1;
			row_cnt = (nxt >= h) ? 12'd0 : 12'(nxt);
		end else begin
			col_cnt = 12'(nxt);
		end
		units_seen++;
	endfunction

	function void check_write(logic [26:0] off, logic [31:0] data, logic refl, logic last);
		fb_write_t e;
		writes_seen++;
		if (refl)
			mirrored_seen++;
		if (expected_writes.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected write: off=%h data=%h refl=%b last=%b",
					off, data, refl, last);
			return;
		end
		e = expected_writes.pop_front();
		if (e.off !== off || e.data !== data || e.refl !== refl || e.last !== last) begin
			mismatches++;
			if (mismatches <= 10)
				$display({"write %0d mismatch: exp off=%h data=%h refl=%b last=%b, ",
					"got off=%h data=%h refl=%b last=%b"},
					writes_seen, e.off, e.data, e.refl, e.last, off, data, refl, last);
		end
	endfunction
endclass

module tb;
	import rbf_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int STALL_CYCLES = 300;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  src_valid = 1'b0;
	logic                  src_ready;
	logic [PIX_W-1:0]      source_unit = '0;
	logic                  wr_valid;
	logic                  wr_ready = 1'b0;
	logic [OFF_W-1:0]      dest_offset;
	logic [PIX_W-1:0]      pixel_data;
	logic                  is_reflection;
	logic                  last;

	blit_scoreboard sb;
	int             src_idle_pct = 0;
	int             rcv_idle_pct = 0;
	int             stall_req = 0;
	int             stall_ack = 0;
	int             hold_left = 0;
	int             settings_cnt = 0;
	logic [31:0]    stim_q[$];

	raster_blit_with_reflection_fade dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.src_valid     (src_valid),
		.src_ready     (src_ready),
		.source_unit   (source_unit),
		.wr_valid      (wr_valid),
		.wr_ready      (wr_ready),
		.dest_offset   (dest_offset),
		.pixel_data    (pixel_data),
		.is_reflection (is_reflection),
		.last          (last)
	);

	always #4 clk = ~clk;

	initial begin : watchdog
		int cyc;
		cyc = 0;
		while (cyc < CYCLE_LIMIT) begin
			@(posedge clk);
			cyc++;
		end
		$display("tb failed");
		$finish;
	end

	// write sink: check accepted writes, random back-pressure, long hold on request
	always @(posedge clk) begin
		if (arst_n) begin
			if (wr_valid && wr_ready)
				sb.check_write(dest_offset, pixel_data, is_reflection, last);
			if (hold_left == 0 && stall_ack != stall_req) begin
				hold_left = STALL_CYCLES;
				stall_ack = stall_req;
			end
			if (hold_left > 0) begin
				hold_left--;
				wr_ready <= 1'b0;
			end else begin
				wr_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
			end
		end
	end

	task automatic write_reg(cfg_idx_t idx, int v);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(v);
		@(posedge clk);
		sb.set_reg(idx, CFG_DATA_W'(v));
	endtask

	task automatic program_blit(fmt_t fmt, int units, int rows, int refl, int stride);
		write_reg(CFG_PIXEL_FORMAT, int'(fmt));
		write_reg(CFG_ROW_UNITS, units);
		write_reg(CFG_IMAGE_ROWS, rows);
		write_reg(CFG_REFLECTION_ROWS, refl);
		write_reg(CFG_DEST_STRIDE, stride);
		cfg_wr_en <= 1'b0;
		settings_cnt++;
	endtask

	task automatic wait_drained();
		while (sb.expected_writes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// offer every queued request; valid stays up between back-to-back requests
	task automatic send_queued();
		logic [31:0] v;
		while (stim_q.size() != 0) begin
			v = stim_q.pop_front();
			while ($urandom_range(0, 99) < src_idle_pct) begin
				src_valid <= 1'b0;
				@(posedge clk);
			end
			src_valid   <= 1'b1;
			source_unit <= v;
			@(posedge clk);
			while (!src_ready)
				@(posedge clk);
			sb.note_unit(v);
		end
		src_valid <= 1'b0;
	endtask

	function automatic logic [31:0] random_unit();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return {8'($urandom_range(0, 255)), 24'h0};
			default: return $urandom();
		endcase
	endfunction

	task automatic random_setup();
		int units, rows, refl, stride;
		case ($urandom_range(0, 9))
			0: units = 0;
			1: units = 8191;
			2: units = 4096;
			default: units = $urandom_range(1, 5);
		endcase
		case ($urandom_range(0, 9))
			0: rows = 0;
			1: rows = 8191;
			2: rows = 4096;
			default: rows = $urandom_range(1, 6);
		endcase
		case ($urandom_range(0, 9))
			0: refl = 0;
			1: refl = 4095;
			2: refl = 2048;
			default: refl = $urandom_range(0, 7);
		endcase
		case ($urandom_range(0, 5))
			0: stride = 0;
			1: stride = 32767;
			2: stride = $urandom_range(1, 32767);
			default: stride = $urandom_range(1, 300);
		endcase
		program_blit(fmt_t'($urandom_range(0, 3)), units, rows, refl, stride);
	endtask

	initial begin
		sb = new();
		src_idle_pct = 19;
		rcv_idle_pct = 65;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset register values: bilevel, 1x1 image, no reflection
		stim_q = '{32'h0000_0000, 32'h0000_00FF};
		send_queued();
		wait_drained();

		// both rows of a 2x2 image mirrored, fade steps 32 and 64
		program_blit(FMT_BILEVEL, 2, 2, 2, 64);
		stim_q = '{32'hFFFF_FFA5, 32'h0000_005A, 32'h0000_0000, 32'h0000_00FF};
		send_queued();
		wait_drained();

		// zero geometry acts as one, reflection taller than image, zero stride
		program_blit(FMT_COPY16, 0, 0, 4095, 0);
		stim_q = '{32'hFFFF_FFFF, 32'h8000_7FFF};
		send_queued();
		wait_drained();

		// oversized geometry, widest stride
		program_blit(FMT_SWAP32, 8191, 8191, 4095, 32767);
		stim_q = '{32'h1122_3344, 32'hFFFF_FFFF, 32'h0000_0000};
		send_queued();
		wait_drained();

		// column already past the new row width; later rows mirror far down, offset wraps
		program_blit(FMT_COPY32, 1, 8191, 4095, 32767);
		stim_q = '{32'hDEAD_BEEF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0001};
		send_queued();
		wait_drained();

		// row already past the new height: no mirror, then wrap to the top
		program_blit(FMT_BILEVEL, 3, 3, 1, 100);
		stim_q = '{32'h0000_0081, 32'h0000_007E, 32'h0000_00C3, 32'h0000_003C,
			32'h0000_0001};
		send_queued();
		wait_drained();

		for (int p = 0; p < 9; p++) begin
			case (p / 3)
				0: begin
					src_idle_pct = 19;
					rcv_idle_pct = 65;
				end
				1: begin
					src_idle_pct = 65;
					rcv_idle_pct = 19;
				end
				default: begin
					src_idle_pct = 0;
					rcv_idle_pct = 0;
				end
			endcase
			random_setup();
			stim_q.delete();
			repeat (28) stim_q.push_back(random_unit());
			// sink holds off while requests keep coming so the block backs up
			if (p == 7)
				stall_req++;
			send_queued();
			wait_drained();
		end

		repeat (40) @(posedge clk);
		$display("run covered %0d source requests and %0d writes (%0d mirrored)",
			sb.units_seen, sb.writes_seen, sb.mirrored_seen);
		$display("over %0d register settings, all four formats, three idle profiles, %0d mismatches",
			settings_cnt, sb.mismatches);
		if (sb.mismatches == 0 && sb.expected_writes.size() == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end
endmodule
